// File: hw/rtl/reps_pkg.sv
// Shared types and constant tables for the rotary encoder preset stepper.
package reps_pkg;

    localparam int unsigned IDX_W    = 4;
    localparam int unsigned ENTRIES  = 16;
    localparam int unsigned DUTY_W   = 8;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned LOCK_W   = 16;
    localparam int unsigned REQ_W    = 8;

    localparam logic [LOCK_W-1:0] LOCKOUT_RESET = 16'd150;

    // Item kinds carried on the input tuser bit
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_SET    = 1'b1;

    // Duty tables: percent * 255 / 100, with 100 percent giving 255.
    // Channel A percents: 2 2 3 3 3 5 6 7 9 12 17 23 33 47 70 100
    localparam logic [DUTY_W-1:0] DUTY_A [ENTRIES] = '{
        8'd5,   8'd5,   8'd7,   8'd7,   8'd7,   8'd12,  8'd15,  8'd17,
        8'd22,  8'd30,  8'd43,  8'd58,  8'd84,  8'd119, 8'd178, 8'd255
    };
    // Channel B percents: 3 3 4 4 4 5 6 7 9 12 17 24 36 53 80 100
    localparam logic [DUTY_W-1:0] DUTY_B [ENTRIES] = '{
        8'd7,   8'd7,   8'd10,  8'd10,  8'd10,  8'd12,  8'd15,  8'd17,
        8'd22,  8'd30,  8'd43,  8'd61,  8'd91,  8'd135, 8'd204, 8'd255
    };

    typedef struct packed {
        logic              kind;
        logic              clk_level;
        logic              dt_level;
        logic [TIME_W-1:0] now_ms;
        logic [REQ_W-1:0]  new_index;
    } item_t;

    typedef struct packed {
        logic              applied;
        logic [DUTY_W-1:0] duty_b;
        logic [DUTY_W-1:0] duty_a;
        logic [IDX_W-1:0]  preset_index;
    } result_t;

endpackage

// File: hw/rtl/reps_in_stage.sv
// Input register stage: captures one sampled item per transfer.
module reps_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  reps_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output reps_pkg::item_t out_item
);
    import reps_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    // Accept when empty or when the held item moves on this cycle
    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_ready)
        begin
            vld_next = in_valid;
        end
    end

    // Hold valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Capture payload on transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// File: hw/rtl/reps_core.sv
// Step logic: edge detect, lockout check, index update, duty lookup, result register.
module reps_core #(
    parameter int unsigned PRESET_COUNT = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [reps_pkg::LOCK_W-1:0] cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  reps_pkg::item_t           in_item,
    output logic                      res_valid,
    input  logic                      res_ready,
    output reps_pkg::result_t         res
);
    import reps_pkg::*;

    localparam logic [IDX_W-1:0] TOP = IDX_W'(PRESET_COUNT - 1);

    logic [LOCK_W-1:0] lockout_reg;
    logic              prev_clk_reg;
    logic              prev_clk_next;
    logic [TIME_W-1:0] last_time_reg;
    logic [TIME_W-1:0] last_time_next;
    logic [IDX_W-1:0]  index_reg;
    logic [IDX_W-1:0]  index_next;
    logic              applied;
    logic              fall;
    logic              open;
    logic [TIME_W-1:0] elapsed;
    logic              fire;
    logic              res_valid_reg;
    result_t           res_reg;
    result_t           res_next;

    assign in_ready  = !res_valid_reg || res_ready;
    assign fire      = in_valid && in_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Falling clock edge and wrapping lockout check
    assign fall    = prev_clk_reg && !in_item.clk_level;
    assign elapsed = in_item.now_ms - last_time_reg;
    assign open    = elapsed >= {{(TIME_W-LOCK_W){1'b0}}, lockout_reg};

    // Next state and result for the item at the input
    always_comb
    begin
        index_next     = index_reg;
        last_time_next = last_time_reg;
        prev_clk_next  = prev_clk_reg;
        applied        = 1'b0;
        if (in_item.kind == KIND_SET)
        begin
            if (in_item.new_index > {{(REQ_W-IDX_W){1'b0}}, TOP})
            begin
                index_next = TOP;
            end
            else
            begin
                index_next = in_item.new_index[IDX_W-1:0];
            end
            applied = 1'b1;
        end
        else
        begin
            if (fall && open)
            begin
                last_time_next = in_item.now_ms;
                applied        = 1'b1;
                if (in_item.dt_level)
                begin
                    index_next = (index_reg < TOP) ? index_reg + 1'b1 : '0;
                end
                else
                begin
                    index_next = (index_reg != '0) ? index_reg - 1'b1 : TOP;
                end
            end
            prev_clk_next = in_item.clk_level;
        end
        res_next.preset_index = index_next;
        res_next.duty_a       = DUTY_A[index_next];
        res_next.duty_b       = DUTY_B[index_next];
        res_next.applied      = applied;
    end

    // Lockout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg <= LOCKOUT_RESET;
        end
        else if (cfg_we)
        begin
            lockout_reg <= cfg_data;
        end
    end

    // Advance state on each consumed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_clk_reg  <= 1'b1;
            last_time_reg <= '0;
            index_reg     <= '0;
        end
        else if (fire)
        begin
            prev_clk_reg  <= prev_clk_next;
            last_time_reg <= last_time_next;
            index_reg     <= index_next;
        end
    end

    // Result valid: set on a new result, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// File: hw/rtl/rotary_encoder_preset_stepper.sv
// Top level of the rotary encoder preset stepper.
// Each input transfer is a polled encoder sample (tuser low) or a direct index
// set (tuser high); every item yields exactly one result carrying the preset
// index, both PWM duties and an applied flag. The block takes one item per
// clock cycle while the result stream is not stalled. An item passes through
// the input register and then the result register, which the step logic
// loads when it takes the item; m_tvalid is driven from the result register.
// A step counts on a falling encoder clock once lockout_ms have passed since
// the last counted step, with wrapping 32-bit time. Write lockout_ms through
// the cfg port only while no items are in flight.
module rotary_encoder_preset_stepper #(
    parameter int unsigned PRESET_COUNT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: lockout_ms
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // clk_level[0], dt_level[1], now_ms[33:2], new_index[41:34]
    input  logic        s_tuser,  // kind[0]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // preset_index[3:0], duty_a[11:4], duty_b[19:12], applied[20]
);
    import reps_pkg::*;

    item_t   in_item;
    item_t   st_item;
    logic    st_valid;
    logic    st_ready;
    result_t res;

    assign cfg_ready = 1'b1;

    // Unpack the input transfer
    assign in_item.kind      = s_tuser;
    assign in_item.clk_level = s_tdata[0];
    assign in_item.dt_level  = s_tdata[1];
    assign in_item.now_ms    = s_tdata[33:2];
    assign in_item.new_index = s_tdata[41:34];

    reps_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (st_valid),
        .out_ready (st_ready),
        .out_item  (st_item)
    );

    reps_core #(
        .PRESET_COUNT (PRESET_COUNT)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .in_valid  (st_valid),
        .in_ready  (st_ready),
        .in_item   (st_item),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result, zero fill to whole bytes
    assign m_tdata = {3'b000, res};

endmodule
